// ===== sv/gjs_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, widths, codes and helper functions of the linear solver.
package gjs_pkg;

    localparam int MAX_ROWS    = 8;
    localparam int MAX_VARS    = 8;
    localparam int COLS_MAX    = MAX_VARS + 1;
    localparam int STORE_DEPTH = MAX_ROWS * COLS_MAX;

    localparam int DATA_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int EPS_W   = 16;
    localparam int CFG_W   = 4;
    localparam int ADDR_W  = $clog2(STORE_DEPTH);
    localparam int LP_W    = $clog2(STORE_DEPTH + 1);
    localparam int CNT_W   = (MAX_ROWS > COLS_MAX) ? $clog2(MAX_ROWS + 1) : $clog2(COLS_MAX + 1);
    localparam int IDX_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int VAR_W   = 3;
    localparam int QUOT_W  = DATA_W + FRAC_W;

    localparam int STATUS_W    = 2;
    localparam int OUT_FIELD_W = STATUS_W + VAR_W + DATA_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam logic [STATUS_W-1:0] ST_UNIQUE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDER  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INCONS = 2'd2;

    localparam logic [1:0] CFG_NUM_ROWS = 2'd0;
    localparam logic [1:0] CFG_NUM_VARS = 2'd1;
    localparam logic [1:0] CFG_EPSILON  = 2'd2;

    typedef logic signed [DATA_W-1:0] q16_t;

    // Magnitude of a Q16.16 value; the most negative value maps to 2^31.
    function automatic logic [DATA_W-1:0] mag(input q16_t v);
        logic [DATA_W-1:0] u;
        begin
            u = v;
            mag = v[DATA_W-1] ? (~u + 1'b1) : u;
        end
    endfunction

endpackage

// ===== sv/gjs_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module gjs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 72
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/gjs_div.sv =====
`timescale 1ns / 1ps
// Radix-2 restoring divider: (|x| << 16 + |d|/2) / |d|, signed and saturated.
module gjs_div import gjs_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  q16_t num,
    input  q16_t den,
    output logic done,
    output q16_t quot
);

    localparam int STEP_W = $clog2(QUOT_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [QUOT_W-1:0] acc_reg, acc_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] dvs_reg, dvs_next;
    logic              neg_reg, neg_next;

    logic [DATA_W:0]   rem_sh;
    logic [DATA_W:0]   rem_sub;
    logic              ge;
    logic [DATA_W-1:0] mag_den;

    always_comb
    begin
        mag_den   = mag(den);
        rem_sh    = {rem_reg, acc_reg[QUOT_W-1]};
        ge        = rem_sh >= {1'b0, dvs_reg};
        rem_sub   = rem_sh - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = STEP_W'(QUOT_W);
            acc_next  = (QUOT_W'(mag(num)) << FRAC_W) + QUOT_W'(mag_den >> 1);
            rem_next  = '0;
            dvs_next  = mag_den;
            neg_next  = num[DATA_W-1] ^ den[DATA_W-1];
        end
        else if (busy_reg)
        begin
            // shift one quotient bit in per cycle
            rem_next = ge ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
            acc_next = {acc_reg[QUOT_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        if (neg_reg)
        begin
            if (acc_reg >= QUOT_W'(64'h8000_0000))
            begin
                quot = q16_t'(32'h8000_0000);
            end
            else
            begin
                quot = q16_t'(32'd0 - acc_reg[DATA_W-1:0]);
            end
        end
        else
        begin
            if (acc_reg > QUOT_W'(64'h7FFF_FFFF))
            begin
                quot = q16_t'(32'h7FFF_FFFF);
            end
            else
            begin
                quot = q16_t'(acc_reg[DATA_W-1:0]);
            end
        end
    end

    assign done = done_reg;

endmodule

// ===== sv/gjs_msub.sv =====
`timescale 1ns / 1ps
// Row update unit: target - floor((factor * source + 0.5) >> 16), saturated.
module gjs_msub import gjs_pkg::*; (
    input  logic clk,
    input  logic load,
    input  q16_t fac,
    input  q16_t src,
    input  q16_t tgt,
    output q16_t res
);

    logic signed [2*DATA_W-1:0] prod_reg, prod_next;
    q16_t                       tgt_reg, tgt_next;
    logic signed [2*DATA_W-1:0] rnd;
    logic signed [2*DATA_W-1:0] t;
    logic signed [2*DATA_W-1:0] diff;

    always_comb
    begin
        prod_next = prod_reg;
        tgt_next  = tgt_reg;
        if (load)
        begin
            prod_next = fac * src;
            tgt_next  = tgt;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        tgt_reg  <= tgt_next;
    end

    always_comb
    begin
        rnd  = prod_reg + 64'sd32768;
        t    = rnd >>> FRAC_W;
        diff = {{DATA_W{tgt_reg[DATA_W-1]}}, tgt_reg} - t;
        if (diff > 64'sd2147483647)
        begin
            res = q16_t'(32'h7FFF_FFFF);
        end
        else if (diff < -64'sd2147483648)
        begin
            res = q16_t'(32'h8000_0000);
        end
        else
        begin
            res = q16_t'(diff[DATA_W-1:0]);
        end
    end

endmodule

// ===== sv/gauss_jordan_linear_solver.sv =====
`timescale 1ns / 1ps
// Gauss-Jordan solver top: element store, sequencer, shared divide and row-update units.
// Load: one element per cycle while idle; the element marked last starts the solve.
// Solve: each pivot-row element is normalised by the bit-serial divider, and each row update
//   reads, multiplies and writes back one element at a time through the one RAM read port.
// Results leave at one per cycle while m_axis_tready is high, through an output register; the
//   block takes no element from solve start until the last result is registered. Async active-low
//   reset clears control state and sets num_rows=8, num_vars=8, epsilon=1; the store is not cleared.
module gauss_jordan_linear_solver import gjs_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    // element transactions
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [DATA_W-1:0]      s_axis_tdata,   // [31:0] element_value
    input  logic                   s_axis_tlast,   // last_element
    // result transactions
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [1:0] solve_status, [4:2] variable_index,
                                                   // [36:5] solution_value, rest zero
    output logic                   m_axis_tlast,   // last_result
    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [EPS_W-1:0]       cfg_data
);

    // sequencer states
    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_COL      = 5'd1;
    localparam logic [4:0] S_SRCH_RD  = 5'd2;
    localparam logic [4:0] S_SRCH_CHK = 5'd3;
    localparam logic [4:0] S_SWP_RA   = 5'd4;
    localparam logic [4:0] S_SWP_RB   = 5'd5;
    localparam logic [4:0] S_SWP_WA   = 5'd6;
    localparam logic [4:0] S_SWP_WB   = 5'd7;
    localparam logic [4:0] S_PV_RD    = 5'd8;
    localparam logic [4:0] S_PV_LAT   = 5'd9;
    localparam logic [4:0] S_NRM_RD   = 5'd10;
    localparam logic [4:0] S_NRM_GO   = 5'd11;
    localparam logic [4:0] S_NRM_WAIT = 5'd12;
    localparam logic [4:0] S_FE_CHK   = 5'd13;
    localparam logic [4:0] S_FE_F     = 5'd14;
    localparam logic [4:0] S_SUB_RS   = 5'd15;
    localparam logic [4:0] S_SUB_RT   = 5'd16;
    localparam logic [4:0] S_SUB_MUL  = 5'd17;
    localparam logic [4:0] S_SUB_WR   = 5'd18;
    localparam logic [4:0] S_BK_P     = 5'd19;
    localparam logic [4:0] S_BK_CHK   = 5'd20;
    localparam logic [4:0] S_BK_F     = 5'd21;
    localparam logic [4:0] S_SC_RD    = 5'd22;
    localparam logic [4:0] S_SC_CHK   = 5'd23;
    localparam logic [4:0] S_DEC      = 5'd24;
    localparam logic [4:0] S_VL_RD    = 5'd25;
    localparam logic [4:0] S_VL_WR    = 5'd26;
    localparam logic [4:0] S_OUT      = 5'd27;

    // configuration registers
    logic [CFG_W-1:0] num_rows_reg, num_rows_next;
    logic [CFG_W-1:0] num_vars_reg, num_vars_next;
    logic [EPS_W-1:0] eps_reg, eps_next;

    // sequencer registers
    logic [4:0]        state_reg, state_next;
    logic [LP_W-1:0]   load_pos_reg, load_pos_next;
    logic [CNT_W-1:0]  prow_reg, prow_next;
    logic [CNT_W-1:0]  col_reg, col_next;
    logic [CNT_W-1:0]  r_reg, r_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]  best_reg, best_next;
    logic [DATA_W-1:0] bv_reg, bv_next;
    logic              found_reg, found_next;
    q16_t              pv_reg, pv_next;
    q16_t              f_reg, f_next;
    q16_t              tmp_reg, tmp_next;
    logic [CNT_W-1:0]  src_reg, src_next;
    logic [CNT_W-1:0]  tgt_reg, tgt_next;
    logic              back_reg, back_next;
    logic [CNT_W-1:0]  np_reg, np_next;
    logic [CNT_W-1:0]  pcnt_reg, pcnt_next;
    logic [CNT_W-1:0]  plist_reg [MAX_ROWS];
    logic [CNT_W-1:0]  plist_next [MAX_ROWS];
    logic              nz_reg, nz_next;
    logic [VAR_W-1:0]  firstj_reg, firstj_next;
    logic [CNT_W-1:0]  pcount_reg, pcount_next;
    logic [VAR_W-1:0]  pcol_reg [MAX_ROWS];
    logic [VAR_W-1:0]  pcol_next [MAX_ROWS];
    logic              incons_reg, incons_next;
    q16_t              vals_reg [MAX_VARS];
    q16_t              vals_next [MAX_VARS];
    logic [STATUS_W-1:0] status_reg, status_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [VAR_W-1:0]    out_idx_reg, out_idx_next;
    q16_t                out_val_reg, out_val_next;
    logic                out_last_reg, out_last_next;

    // store port
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;
    q16_t              rd_val;

    // arithmetic units
    logic div_start;
    logic div_done;
    q16_t div_quot;
    logic ms_load;
    q16_t ms_res;

    // effective sizes
    logic [CNT_W-1:0] rows_eff;
    logic [CNT_W-1:0] nv_eff;
    logic [CNT_W-1:0] cols_eff;
    logic [LP_W-1:0]  load_limit;
    logic [DATA_W-1:0] eps_w;
    logic [DATA_W-1:0] rd_mag;
    logic              rd_big;
    logic              in_acc;

    function automatic logic [ADDR_W-1:0] saddr(input logic [CNT_W-1:0] row,
                                               input logic [CNT_W-1:0] cols,
                                               input logic [CNT_W-1:0] c);
        begin
            saddr = ADDR_W'(LP_W'(row) * LP_W'(cols) + LP_W'(c));
        end
    endfunction

    // clamp the register counts to the supported range
    always_comb
    begin
        if (num_rows_reg == '0)
        begin
            rows_eff = CNT_W'(1);
        end
        else if (num_rows_reg > CFG_W'(MAX_ROWS))
        begin
            rows_eff = CNT_W'(MAX_ROWS);
        end
        else
        begin
            rows_eff = CNT_W'(num_rows_reg);
        end
        if (num_vars_reg == '0)
        begin
            nv_eff = CNT_W'(1);
        end
        else if (num_vars_reg > CFG_W'(MAX_VARS))
        begin
            nv_eff = CNT_W'(MAX_VARS);
        end
        else
        begin
            nv_eff = CNT_W'(num_vars_reg);
        end
        cols_eff   = nv_eff + 1'b1;
        load_limit = LP_W'(LP_W'(rows_eff) * LP_W'(cols_eff));
    end

    assign rd_val = q16_t'(ram_rdata);
    assign eps_w  = DATA_W'(eps_reg);
    assign rd_mag = mag(rd_val);
    assign rd_big = rd_mag > eps_w;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // configuration writes; indexes past the list are ignored
    always_comb
    begin
        num_rows_next = num_rows_reg;
        num_vars_next = num_vars_reg;
        eps_next      = eps_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_NUM_ROWS: num_rows_next = cfg_data[CFG_W-1:0];
                CFG_NUM_VARS: num_vars_next = cfg_data[CFG_W-1:0];
                CFG_EPSILON:  eps_next      = cfg_data;
                default:      ;
            endcase
        end
    end

    // store read address for each state; read data shows up in the next cycle
    always_comb
    begin
        case (state_reg)
            S_SRCH_RD: ram_raddr = saddr(r_reg, cols_eff, col_reg);
            S_SWP_RA:  ram_raddr = saddr(prow_reg, cols_eff, k_reg);
            S_SWP_RB:  ram_raddr = saddr(best_reg, cols_eff, k_reg);
            S_PV_RD:   ram_raddr = saddr(prow_reg, cols_eff, col_reg);
            S_NRM_RD:  ram_raddr = saddr(prow_reg, cols_eff, k_reg);
            S_FE_CHK:  ram_raddr = saddr(r_reg, cols_eff, col_reg);
            S_SUB_RS:  ram_raddr = saddr(src_reg, cols_eff, k_reg);
            S_SUB_RT:  ram_raddr = saddr(tgt_reg, cols_eff, k_reg);
            S_BK_CHK:  ram_raddr = saddr(r_reg - 1'b1, cols_eff, col_reg);
            S_SC_RD:   ram_raddr = saddr(r_reg, cols_eff, k_reg);
            S_VL_RD:   ram_raddr = saddr(r_reg, cols_eff, nv_eff);
            default:   ram_raddr = '0;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        load_pos_next = load_pos_reg;
        prow_next     = prow_reg;
        col_next      = col_reg;
        r_next        = r_reg;
        k_next        = k_reg;
        best_next     = best_reg;
        bv_next       = bv_reg;
        found_next    = found_reg;
        pv_next       = pv_reg;
        f_next        = f_reg;
        tmp_next      = tmp_reg;
        src_next      = src_reg;
        tgt_next      = tgt_reg;
        back_next     = back_reg;
        np_next       = np_reg;
        pcnt_next     = pcnt_reg;
        plist_next    = plist_reg;
        nz_next       = nz_reg;
        firstj_next   = firstj_reg;
        pcount_next   = pcount_reg;
        pcol_next     = pcol_reg;
        incons_next   = incons_reg;
        vals_next     = vals_reg;
        status_next   = status_reg;

        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_idx_next    = out_idx_reg;
        out_val_next    = out_val_reg;
        out_last_next   = out_last_reg;

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        div_start = 1'b0;
        ms_load   = 1'b0;

        // drop the output transaction once taken
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (load_pos_reg < load_limit)
                    begin
                        ram_we        = 1'b1;
                        ram_waddr     = load_pos_reg[ADDR_W-1:0];
                        ram_wdata     = s_axis_tdata;
                        load_pos_next = load_pos_reg + 1'b1;
                    end
                    if (s_axis_tlast)
                    begin
                        load_pos_next = '0;
                        prow_next     = '0;
                        col_next      = '0;
                        np_next       = '0;
                        for (int i = 0; i < MAX_VARS; i++)
                        begin
                            vals_next[i] = '0;
                        end
                        state_next = S_COL;
                    end
                end
            end

            S_COL:
            begin
                if (col_reg < cols_eff && prow_reg < rows_eff)
                begin
                    r_next     = prow_reg;
                    found_next = 1'b0;
                    bv_next    = eps_w;
                    state_next = S_SRCH_RD;
                end
                else
                begin
                    pcnt_next  = np_reg;
                    state_next = S_BK_P;
                end
            end

            S_SRCH_RD:
            begin
                state_next = S_SRCH_CHK;
            end

            S_SRCH_CHK:
            begin
                if (rd_mag > bv_reg)
                begin
                    bv_next    = rd_mag;
                    best_next  = r_reg;
                    found_next = 1'b1;
                end
                if (r_reg + 1'b1 < rows_eff)
                begin
                    r_next     = r_reg + 1'b1;
                    state_next = S_SRCH_RD;
                end
                else if (!found_next)
                begin
                    col_next   = col_reg + 1'b1;
                    state_next = S_COL;
                end
                else if (best_next != prow_reg)
                begin
                    k_next     = '0;
                    state_next = S_SWP_RA;
                end
                else
                begin
                    state_next = S_PV_RD;
                end
            end

            S_SWP_RA:
            begin
                state_next = S_SWP_RB;
            end

            S_SWP_RB:
            begin
                tmp_next   = rd_val;
                state_next = S_SWP_WA;
            end

            S_SWP_WA:
            begin
                ram_we     = 1'b1;
                ram_waddr  = saddr(prow_reg, cols_eff, k_reg);
                ram_wdata  = ram_rdata;
                state_next = S_SWP_WB;
            end

            S_SWP_WB:
            begin
                ram_we    = 1'b1;
                ram_waddr = saddr(best_reg, cols_eff, k_reg);
                ram_wdata = tmp_reg;
                if (k_reg + 1'b1 < cols_eff)
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_SWP_RA;
                end
                else
                begin
                    state_next = S_PV_RD;
                end
            end

            S_PV_RD:
            begin
                state_next = S_PV_LAT;
            end

            S_PV_LAT:
            begin
                pv_next    = rd_val;
                k_next     = '0;
                state_next = S_NRM_RD;
            end

            S_NRM_RD:
            begin
                state_next = S_NRM_GO;
            end

            S_NRM_GO:
            begin
                div_start  = 1'b1;
                state_next = S_NRM_WAIT;
            end

            S_NRM_WAIT:
            begin
                if (div_done)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = saddr(prow_reg, cols_eff, k_reg);
                    ram_wdata = div_quot;
                    if (k_reg + 1'b1 < cols_eff)
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_NRM_RD;
                    end
                    else
                    begin
                        r_next     = prow_reg + 1'b1;
                        state_next = S_FE_CHK;
                    end
                end
            end

            S_FE_CHK:
            begin
                if (r_reg < rows_eff)
                begin
                    state_next = S_FE_F;
                end
                else
                begin
                    // column done: record the pivot and advance
                    plist_next[np_reg[IDX_W-1:0]] = col_reg;
                    np_next    = np_reg + 1'b1;
                    prow_next  = prow_reg + 1'b1;
                    col_next   = col_reg + 1'b1;
                    state_next = S_COL;
                end
            end

            S_FE_F:
            begin
                f_next = rd_val;
                if (rd_big)
                begin
                    src_next   = prow_reg;
                    tgt_next   = r_reg;
                    k_next     = '0;
                    back_next  = 1'b0;
                    state_next = S_SUB_RS;
                end
                else
                begin
                    r_next     = r_reg + 1'b1;
                    state_next = S_FE_CHK;
                end
            end

            S_SUB_RS:
            begin
                state_next = S_SUB_RT;
            end

            S_SUB_RT:
            begin
                tmp_next   = rd_val;
                state_next = S_SUB_MUL;
            end

            S_SUB_MUL:
            begin
                ms_load    = 1'b1;
                state_next = S_SUB_WR;
            end

            S_SUB_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = saddr(tgt_reg, cols_eff, k_reg);
                ram_wdata = ms_res;
                if (k_reg + 1'b1 < cols_eff)
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_SUB_RS;
                end
                else if (back_reg)
                begin
                    r_next     = r_reg - 1'b1;
                    state_next = S_BK_CHK;
                end
                else
                begin
                    r_next     = r_reg + 1'b1;
                    state_next = S_FE_CHK;
                end
            end

            S_BK_P:
            begin
                if (pcnt_reg != '0)
                begin
                    src_next   = pcnt_reg - 1'b1;
                    col_next   = plist_reg[IDX_W'(pcnt_reg - 1'b1)];
                    r_next     = pcnt_reg - 1'b1;
                    state_next = S_BK_CHK;
                end
                else
                begin
                    r_next      = '0;
                    k_next      = '0;
                    nz_next     = 1'b0;
                    pcount_next = '0;
                    incons_next = 1'b0;
                    state_next  = S_SC_RD;
                end
            end

            S_BK_CHK:
            begin
                if (r_reg != '0)
                begin
                    state_next = S_BK_F;
                end
                else
                begin
                    pcnt_next  = pcnt_reg - 1'b1;
                    state_next = S_BK_P;
                end
            end

            S_BK_F:
            begin
                f_next = rd_val;
                if (rd_big)
                begin
                    tgt_next   = r_reg - 1'b1;
                    k_next     = '0;
                    back_next  = 1'b1;
                    state_next = S_SUB_RS;
                end
                else
                begin
                    r_next     = r_reg - 1'b1;
                    state_next = S_BK_CHK;
                end
            end

            S_SC_RD:
            begin
                state_next = S_SC_CHK;
            end

            S_SC_CHK:
            begin
                if (k_reg < nv_eff)
                begin
                    // first coefficient above epsilon in this row
                    if (rd_big && !nz_reg)
                    begin
                        nz_next     = 1'b1;
                        firstj_next = k_reg[VAR_W-1:0];
                    end
                    k_next     = k_reg + 1'b1;
                    state_next = S_SC_RD;
                end
                else
                begin
                    // right-hand side of a row with all-zero coefficients
                    if (!nz_reg && rd_big)
                    begin
                        incons_next = 1'b1;
                    end
                    if (nz_reg && pcount_reg < np_reg)
                    begin
                        pcol_next[pcount_reg[IDX_W-1:0]] = firstj_reg;
                        pcount_next = pcount_reg + 1'b1;
                    end
                    nz_next = 1'b0;
                    k_next  = '0;
                    if (r_reg + 1'b1 < rows_eff)
                    begin
                        r_next     = r_reg + 1'b1;
                        state_next = S_SC_RD;
                    end
                    else
                    begin
                        state_next = S_DEC;
                    end
                end
            end

            S_DEC:
            begin
                r_next = '0;
                k_next = '0;
                if (incons_reg)
                begin
                    status_next = ST_INCONS;
                    state_next  = S_OUT;
                end
                else if (pcount_reg < nv_eff)
                begin
                    status_next = ST_UNDER;
                    state_next  = S_OUT;
                end
                else
                begin
                    status_next = ST_UNIQUE;
                    state_next  = S_VL_RD;
                end
            end

            S_VL_RD:
            begin
                state_next = S_VL_WR;
            end

            S_VL_WR:
            begin
                vals_next[pcol_reg[r_reg[IDX_W-1:0]]] = rd_val;
                if (r_reg + 1'b1 < nv_eff)
                begin
                    r_next     = r_reg + 1'b1;
                    state_next = S_VL_RD;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end

            S_OUT:
            begin
                // k counts the result being issued
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    if (status_reg == ST_UNIQUE)
                    begin
                        out_idx_next  = k_reg[VAR_W-1:0];
                        out_val_next  = vals_reg[k_reg[IDX_W-1:0]];
                        out_last_next = (k_reg + 1'b1 == nv_eff);
                    end
                    else
                    begin
                        out_idx_next  = '0;
                        out_val_next  = '0;
                        out_last_next = 1'b1;
                    end
                    if (status_reg != ST_UNIQUE || k_reg + 1'b1 == nv_eff)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg  <= CFG_W'(MAX_ROWS);
            num_vars_reg  <= CFG_W'(MAX_VARS);
            eps_reg       <= EPS_W'(1);
            state_reg     <= S_IDLE;
            load_pos_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            num_rows_reg  <= num_rows_next;
            num_vars_reg  <= num_vars_next;
            eps_reg       <= eps_next;
            state_reg     <= state_next;
            load_pos_reg  <= load_pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prow_reg       <= prow_next;
        col_reg        <= col_next;
        r_reg          <= r_next;
        k_reg          <= k_next;
        best_reg       <= best_next;
        bv_reg         <= bv_next;
        found_reg      <= found_next;
        pv_reg         <= pv_next;
        f_reg          <= f_next;
        tmp_reg        <= tmp_next;
        src_reg        <= src_next;
        tgt_reg        <= tgt_next;
        back_reg       <= back_next;
        np_reg         <= np_next;
        pcnt_reg       <= pcnt_next;
        plist_reg      <= plist_next;
        nz_reg         <= nz_next;
        firstj_reg     <= firstj_next;
        pcount_reg     <= pcount_next;
        pcol_reg       <= pcol_next;
        incons_reg     <= incons_next;
        vals_reg       <= vals_next;
        status_reg     <= status_next;
        out_status_reg <= out_status_next;
        out_idx_reg    <= out_idx_next;
        out_val_reg    <= out_val_next;
        out_last_reg   <= out_last_next;
    end

    gjs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    gjs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (rd_val),
        .den   (pv_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    gjs_msub u_msub (
        .clk  (clk),
        .load (ms_load),
        .fac  (f_reg),
        .src  (tmp_reg),
        .tgt  (rd_val),
        .res  (ms_res)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - OUT_FIELD_W)'(0), out_val_reg, out_idx_reg,
                            out_status_reg};

endmodule

// ===== dv/gauss_jordan_linear_solver_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the linear solver: tracks registers, predicts each solve and checks results.
module gauss_jordan_linear_solver_checker import gjs_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [DATA_W-1:0]      s_axis_tdata,
    input  logic                   s_axis_tlast,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   m_axis_tlast,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [EPS_W-1:0]       cfg_data,
    output int                     pending_results,
    output int                     error_count
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VAR_W-1:0]    var_idx;
        logic [DATA_W-1:0]   value;
        logic                last;
    } solution_t;

    solution_t         solution_q[$];
    logic signed [31:0] mat [0:STORE_DEPTH-1];
    int                piv_col_list [0:MAX_ROWS-1];
    int                pivots_found;
    int                fill_pos;
    logic [3:0]        rows_reg;
    logic [3:0]        vars_reg;
    logic [15:0]       eps_reg;

    function automatic logic [31:0] abs_q(logic signed [31:0] v);
        logic [31:0] u;
        u = v;
        return v[31] ? (~u + 32'd1) : u;
    endfunction

    function automatic int clamp_dim(logic [3:0] v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    function automatic logic signed [31:0] sat_q(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // Q16.16 divide, round half away from zero, saturating
    function automatic logic signed [31:0] div_q(logic signed [31:0] x, logic signed [31:0] d);
        longint unsigned num;
        longint unsigned den;
        longint unsigned q;
        logic            neg;
        num = {32'd0, abs_q(x)} << 16;
        den = {32'd0, abs_q(d)};
        neg = x[31] ^ d[31];
        if (den == 0) return 32'sd0;
        q = (num + den / 2) / den;
        if (neg)
        begin
            if (q >= 64'h80000000) return 32'sh80000000;
            return 32'd0 - q[31:0];
        end
        if (q > 64'h7fffffff) return 32'sh7fffffff;
        return q[31:0];
    endfunction

    // target row -= factor * source row, product rounded down after adding half
    function automatic void row_subtract(int tgt, int src, logic signed [31:0] f, int cols);
        longint prod;
        for (int k = 0; k < cols; k++)
        begin
            prod = (longint'(f) * longint'(mat[src * cols + k]) + 64'sd32768) >>> 16;
            mat[tgt * cols + k] = sat_q(longint'(mat[tgt * cols + k]) - prod);
        end
    endfunction

    function automatic void reduce_matrix(int rows, int cols);
        int                 prow;
        int                 best;
        logic [31:0]        best_mag;
        logic signed [31:0] pv;
        logic signed [31:0] tmp;
        logic signed [31:0] f;
        int                 pc;
        prow = 0;
        pivots_found = 0;
        for (int col = 0; col < cols && prow < rows; col++)
        begin
            best = -1;
            best_mag = {16'd0, eps_reg};
            for (int r = prow; r < rows; r++)
                if (abs_q(mat[r * cols + col]) > best_mag)
                begin
                    best_mag = abs_q(mat[r * cols + col]);
                    best = r;
                end
            if (best < 0) continue;
            if (best != prow)
                for (int k = 0; k < cols; k++)
                begin
                    tmp = mat[prow * cols + k];
                    mat[prow * cols + k] = mat[best * cols + k];
                    mat[best * cols + k] = tmp;
                end
            pv = mat[prow * cols + col];
            for (int k = 0; k < cols; k++)
                mat[prow * cols + k] = div_q(mat[prow * cols + k], pv);
            for (int r = prow + 1; r < rows; r++)
            begin
                f = mat[r * cols + col];
                if (abs_q(f) > {16'd0, eps_reg}) row_subtract(r, prow, f, cols);
            end
            piv_col_list[pivots_found] = col;
            pivots_found++;
            prow++;
        end
        // back substitution, last pivot first
        for (int p = pivots_found - 1; p >= 0; p--)
        begin
            pc = piv_col_list[p];
            for (int r = p; r > 0; r--)
            begin
                f = mat[(r - 1) * cols + pc];
                if (abs_q(f) > {16'd0, eps_reg}) row_subtract(r - 1, p, f, cols);
            end
        end
    endfunction

    function automatic void predict_element(logic signed [31:0] v, logic last);
        int                 rows;
        int                 nv;
        int                 cols;
        int                 lead [0:MAX_ROWS-1];
        int                 nlead;
        logic signed [31:0] vals [0:MAX_VARS-1];
        logic               row_clear;
        solution_t          s;
        rows = clamp_dim(rows_reg, MAX_ROWS);
        nv   = clamp_dim(vars_reg, MAX_VARS);
        cols = nv + 1;
        if (fill_pos < rows * cols)
        begin
            mat[fill_pos] = v;
            fill_pos++;
        end
        if (!last) return;
        fill_pos = 0;
        reduce_matrix(rows, cols);
        nlead = 0;
        for (int i = 0; i < rows && nlead < pivots_found; i++)
            for (int j = 0; j < nv; j++)
                if (abs_q(mat[i * cols + j]) > {16'd0, eps_reg})
                begin
                    lead[nlead] = j;
                    nlead++;
                    break;
                end
        s = '0;
        s.last = 1'b1;
        for (int i = 0; i < rows; i++)
        begin
            row_clear = 1'b1;
            for (int j = 0; j < nv; j++)
                if (abs_q(mat[i * cols + j]) > {16'd0, eps_reg}) row_clear = 1'b0;
            if (row_clear && abs_q(mat[i * cols + nv]) > {16'd0, eps_reg})
            begin
                s.status = ST_INCONS;
                solution_q.push_back(s);
                return;
            end
        end
        if (nlead < nv)
        begin
            s.status = ST_UNDER;
            solution_q.push_back(s);
            return;
        end
        for (int j = 0; j < MAX_VARS; j++) vals[j] = 32'sd0;
        for (int i = 0; i < nlead && i < nv; i++) vals[lead[i]] = mat[i * cols + nv];
        for (int j = 0; j < nv; j++)
        begin
            s.status  = ST_UNIQUE;
            s.var_idx = j[VAR_W-1:0];
            s.value   = vals[j];
            s.last    = (j + 1 == nv);
            solution_q.push_back(s);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        solution_t want;
        if (!rst_n)
        begin
            rows_reg = 4'd8;
            vars_reg = 4'd8;
            eps_reg  = 16'd1;
            fill_pos = 0;
            error_count = 0;
            for (int i = 0; i < STORE_DEPTH; i++) mat[i] = 32'sd0;
            solution_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    CFG_NUM_ROWS: rows_reg = cfg_data[3:0];
                    CFG_NUM_VARS: vars_reg = cfg_data[3:0];
                    CFG_EPSILON:  eps_reg  = cfg_data;
                    default: ;
                endcase
            if (s_axis_tvalid && s_axis_tready)
                predict_element(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (solution_q.size() == 0)
                begin
                    $error("result transaction with nothing expected: tdata=%h", m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    want = solution_q.pop_front();
                    if (m_axis_tdata[1:0] !== want.status)
                    begin
                        $error("solve_status: expected %0d, got %0d",
                               want.status, m_axis_tdata[1:0]);
                        error_count++;
                    end
                    if (m_axis_tdata[4:2] !== want.var_idx)
                    begin
                        $error("variable_index: expected %0d, got %0d",
                               want.var_idx, m_axis_tdata[4:2]);
                        error_count++;
                    end
                    if (m_axis_tdata[36:5] !== want.value)
                    begin
                        $error("solution_value: expected %h, got %h",
                               want.value, m_axis_tdata[36:5]);
                        error_count++;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $error("last_result: expected %b, got %b", want.last, m_axis_tlast);
                        error_count++;
                    end
                end
            end
        end
        pending_results = solution_q.size();
    end

endmodule

// ===== dv/gauss_jordan_linear_solver_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the linear solver: clock, reset, stimulus and the final verdict.
module gauss_jordan_linear_solver_tb;
    import gjs_pkg::*;

    // register index past the list; writes to it are ignored
    localparam logic [1:0] CFG_UNMAPPED = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [DATA_W-1:0]      s_axis_tdata = '0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [1:0]             cfg_index = CFG_NUM_ROWS;
    logic [EPS_W-1:0]       cfg_data = '0;

    int pending_results;
    int error_count;

    // Stimulus-side bookkeeping
    int  elements_sent;
    int  rows_now;       // clamped row count in effect
    int  vars_now;       // clamped variable count in effect
    int  written_depth;  // store entries 0..written_depth-1 hold data since reset
    bit  no_gaps;        // stretch with back-to-back transactions on both sides

    always #5 clk = ~clk;

    gauss_jordan_linear_solver dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    gauss_jordan_linear_solver_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tlast    (s_axis_tlast),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tlast    (m_axis_tlast),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .pending_results (pending_results),
        .error_count     (error_count)
    );

    // Result side: after each accepted transaction, tready may drop for a random stall.
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin : result_sink
        int n;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end
        else if (m_axis_tready && m_axis_tvalid)
        begin
            n = no_gaps ? 0 : $urandom_range(0, 17);
            stall_left = n;
            m_axis_tready <= (n == 0);
        end
        else if (!m_axis_tready)
        begin
            if (stall_left <= 1)
                m_axis_tready <= 1'b1;
            if (stall_left > 0)
                stall_left--;
        end
    end

    // Hold one element on the stream until it is accepted; a random gap goes first.
    task automatic send_element(input logic [31:0] v, input logic last);
        int g;
        g = no_gaps ? 0 : $urandom_range(0, 17);
        if (g > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        elements_sent++;
    endtask

    // Stop sending and wait for every predicted result, then let the block settle.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
        repeat (20) @(posedge clk);
    endtask

    // Register writes happen only with the block drained.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_NUM_ROWS: rows_now = (value[3:0] < 1) ? 1 : (value[3:0] > 8 ? 8 : value[3:0]);
            CFG_NUM_VARS: vars_now = (value[3:0] < 1) ? 1 : (value[3:0] > 8 ? 8 : value[3:0]);
            default: ;
        endcase
    endtask

    task automatic send_list(input logic [31:0] vals[$]);
        for (int i = 0; i < vals.size(); i++)
            send_element(vals[i], i == vals.size() - 1);
        if (vals.size() > written_depth)
            written_depth = (vals.size() < rows_now * (vars_now + 1)) ?
                            vals.size() : rows_now * (vars_now + 1);
    endtask

    function automatic logic [31:0] small_q();
        logic [31:0] v;
        v = $signed($urandom_range(0, 8) - 4) <<< 16;
        if ($urandom_range(0, 3) == 0)
            v = v + $urandom_range(0, 65535);
        return v;
    endfunction

    function automatic logic [31:0] extreme_q();
        case ($urandom_range(0, 5))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return 32'h00000000;
            3: return 32'h00000001;
            4: return 32'hffffffff;
            default: return 32'h00010000;
        endcase
    endfunction

    // Build one matrix of a random flavor and send it, sometimes short or overlong.
    task automatic send_random_matrix();
        logic [31:0] vals[$];
        logic [31:0] first_row [0:8];
        int          flavor;
        int          cols;
        int          n;
        int          zc;
        int          zr;
        logic [31:0] v;
        cols = vars_now + 1;
        n = rows_now * cols;
        flavor = $urandom_range(0, 7);
        zc = $urandom_range(0, vars_now - 1);
        zr = $urandom_range(0, rows_now - 1);
        for (int r = 0; r < rows_now; r++)
            for (int c = 0; c < cols; c++)
            begin
                case (flavor)
                    0, 1: v = small_q();
                    2: v = $urandom();
                    3: v = extreme_q();
                    4: v = (c == zc) ? 32'd0 : small_q();           // missing pivot column
                    5: v = (r == zr && c != vars_now) ? 32'd0 :      // zero row, live rhs
                           (r == zr ? 32'h00030000 : small_q());
                    6: v = (r > 0 && r == zr) ? first_row[c] : small_q(); // repeated row
                    default: v = ($urandom_range(0, 1) != 0) ? $urandom() : small_q();
                endcase
                if (r == 0) first_row[c] = v;
                vals.push_back(v);
            end
        case ($urandom_range(0, 9))
            0: if (written_depth >= n) vals = vals[0:$urandom_range(0, n - 1)];
            1: repeat ($urandom_range(1, 4)) vals.push_back($urandom());
            default: ;
        endcase
        send_list(vals);
    endtask

    initial
    begin
        logic [31:0] m[$];
        int          dim_r;
        int          dim_v;
        elements_sent = 0;
        rows_now = 8;
        vars_now = 8;
        written_depth = 0;
        no_gaps = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: unique 2x2, then an inconsistent pair of parallel equations
        write_reg(CFG_NUM_ROWS, 16'd2);
        write_reg(CFG_NUM_VARS, 16'd2);
        write_reg(CFG_EPSILON, 16'd1);
        m = '{32'h00010000, 32'h00010000, 32'h00030000,
              32'h00010000, 32'hffff0000, 32'h00010000};
        send_list(m);
        m = '{32'h00010000, 32'h00010000, 32'h00010000,
              32'h00010000, 32'h00010000, 32'h00020000};
        send_list(m);
        // Short matrix: only the first element replaced, the rest is last solve's result
        m = '{32'h00020000};
        send_list(m);
        drain_results();
        // One equation, two unknowns: underdetermined
        write_reg(CFG_NUM_ROWS, 16'd1);
        m = '{32'h00010000, 32'h00020000, 32'h00030000};
        send_list(m);
        drain_results();
        // 1x1: pivot lands in the right-hand side, then full-scale divide operands, then overlong
        write_reg(CFG_NUM_VARS, 16'd1);
        m = '{32'h00000000, 32'h00050000};
        send_list(m);
        m = '{32'h80000000, 32'h7fffffff};
        send_list(m);
        m = '{32'h7fffffff, 32'h80000000, 32'h00000001};
        send_list(m);
        drain_results();

        // Random phases: drain, reprogram, then a few matrices
        while (elements_sent < 300)
        begin
            drain_results();
            no_gaps = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
            begin
                dim_r = 8;
                dim_v = 8;
            end
            else
            begin
                dim_r = $urandom_range(1, 4);
                dim_v = $urandom_range(1, 4);
            end
            // out-of-range counts clamp; upper data bits are don't-care
            if ($urandom_range(0, 7) == 0) dim_r = ($urandom_range(0, 1) != 0) ? 0 : 15;
            if ($urandom_range(0, 7) == 0) dim_v = ($urandom_range(0, 1) != 0) ? 0 : 9;
            write_reg(CFG_NUM_ROWS, {12'($urandom_range(0, 4095)), dim_r[3:0]});
            write_reg(CFG_NUM_VARS, {12'($urandom_range(0, 4095)), dim_v[3:0]});
            case ($urandom_range(0, 4))
                0: write_reg(CFG_EPSILON, 16'd0);
                1: write_reg(CFG_EPSILON, 16'hffff);
                2: write_reg(CFG_EPSILON, 16'd1);
                default: write_reg(CFG_EPSILON, 16'($urandom_range(0, 65535)));
            endcase
            if ($urandom_range(0, 15) == 0)
                write_reg(CFG_UNMAPPED, 16'($urandom_range(0, 65535)));
            repeat ($urandom_range(1, 4))
                if (elements_sent < 300)
                    send_random_matrix();
        end

        drain_results();
        repeat (100) @(posedge clk);
        if (error_count == 0 && pending_results == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
